// ----- rtl/psd_pkg.sv -----
// Shared widths, types and codes for the point-to-segment distance pipeline.
package psd_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned T_BITS     = 16;
  localparam int unsigned PARAM_BITS = T_BITS + 1;
  localparam int unsigned DIST_BITS  = COORD_BITS + 1;
  localparam int unsigned DIFF_BITS  = COORD_BITS + 1;
  localparam int unsigned PROD_BITS  = 2 * DIFF_BITS;
  localparam int unsigned ACC_BITS   = PROD_BITS + 2;
  localparam int unsigned REM_BITS   = ACC_BITS + 1;
  localparam int unsigned SCALE_BITS = DIFF_BITS + PARAM_BITS;
  localparam int unsigned ERR_BITS   = DIFF_BITS + 2;
  localparam int unsigned SQ_BITS    = 2 * ERR_BITS;
  localparam int unsigned SUM_BITS   = SQ_BITS + 2;
  localparam int unsigned ROOT_BITS  = SUM_BITS / 2;
  localparam int unsigned SREM_BITS  = ROOT_BITS + 3;
  localparam int unsigned AXES       = 3;

  localparam logic [PARAM_BITS-1:0] PARAM_ONE = PARAM_BITS'(1) << T_BITS;

  typedef enum logic [1:0] {
    KIND_INTERIOR = 2'd0,
    KIND_START    = 2'd1,
    KIND_END      = 2'd2
  } clamp_kind_e;

  typedef struct packed {
    logic [PARAM_BITS-1:0] param;
    clamp_kind_e           kind;
    logic                  degen;
  } tag_t;

endpackage

// ----- rtl/point_segment_distance.sv -----
// Pipelined 3-D point-to-segment distance with clamped projection parameter.
// Throughput: one transaction per cycle; busy is never raised.
// Cost is set by the 16 quotient stages and 36 square-root stages, one bit each.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module point_segment_distance (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [psd_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] point_y_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] point_z_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] start_x_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] start_y_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] start_z_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] end_x_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] end_y_i,
  input  logic signed [psd_pkg::COORD_BITS-1:0] end_z_i,
  output logic                                done_o,
  output logic [psd_pkg::DIST_BITS-1:0]       distance_o,
  output logic [psd_pkg::PARAM_BITS-1:0]      seg_param_o,
  output psd_pkg::clamp_kind_e                clamp_kind_o,
  output logic                                degenerate_o
);
  import psd_pkg::*;

  logic signed [COORD_BITS-1:0] p [AXES];
  logic signed [COORD_BITS-1:0] a [AXES];
  logic signed [COORD_BITS-1:0] b [AXES];

  assign busy = 1'b0;

  assign p[0] = point_x_i;
  assign p[1] = point_y_i;
  assign p[2] = point_z_i;
  assign a[0] = start_x_i;
  assign a[1] = start_y_i;
  assign a[2] = start_z_i;
  assign b[0] = end_x_i;
  assign b[1] = end_y_i;
  assign b[2] = end_z_i;

  // Stage 1: differences
  logic                        v1_q;
  logic signed [DIFF_BITS-1:0] d1_q  [AXES];
  logic signed [DIFF_BITS-1:0] ap1_q [AXES];

  // Stage 2: products
  logic                        v2_q;
  logic [PROD_BITS-1:0]        sq2_q [AXES];
  logic signed [PROD_BITS-1:0] dt2_q [AXES];
  logic signed [DIFF_BITS-1:0] d2_q  [AXES];
  logic signed [DIFF_BITS-1:0] ap2_q [AXES];

  // Stage 3: sums
  logic                        v3_q;
  logic [ACC_BITS-1:0]         ab3_q;
  logic signed [ACC_BITS-1:0]  dot3_q;
  logic signed [DIFF_BITS-1:0] d3_q  [AXES];
  logic signed [DIFF_BITS-1:0] ap3_q [AXES];

  // Stage 4 and quotient stages
  logic                        dv_q  [T_BITS+1];
  logic [REM_BITS-1:0]         dr_q  [T_BITS+1];
  logic [ACC_BITS-1:0]         dab_q [T_BITS+1];
  tag_t                        dtag_q [T_BITS+1];
  logic signed [DIFF_BITS-1:0] dd_q  [T_BITS+1][AXES];
  logic signed [DIFF_BITS-1:0] dap_q [T_BITS+1][AXES];

  // Offset stage
  logic                        vm_q;
  tag_t                        mtag_q;
  logic [DIFF_BITS-1:0]        off_q [AXES];
  logic                        neg_q [AXES];
  logic signed [DIFF_BITS-1:0] apm_q [AXES];

  // Error, square and sum stages
  logic                        ve_q;
  tag_t                        etag_q;
  logic signed [ERR_BITS-1:0]  e_q [AXES];
  logic                        vs_q;
  tag_t                        stag_q;
  logic [SQ_BITS-1:0]          esq_q [AXES];
  logic                        vn_q;
  tag_t                        ntag_q;
  logic [SUM_BITS-1:0]         n_q;

  // Square-root stages
  logic                        rv_q    [ROOT_BITS+1];
  logic [SUM_BITS-1:0]         rn_q    [ROOT_BITS+1];
  logic [SREM_BITS-1:0]        rrem_q  [ROOT_BITS+1];
  logic [ROOT_BITS-1:0]        rroot_q [ROOT_BITS+1];
  tag_t                        rtag_q  [ROOT_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vm_q <= 1'b0;
      ve_q <= 1'b0;
      vs_q <= 1'b0;
      vn_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vm_q <= dv_q[T_BITS];
      ve_q <= vm_q;
      vs_q <= ve_q;
      vn_q <= vs_q;
      done_o <= rv_q[ROOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < AXES; i++) begin
      d1_q[i]  <= DIFF_BITS'(b[i]) - DIFF_BITS'(a[i]);
      ap1_q[i] <= DIFF_BITS'(p[i]) - DIFF_BITS'(a[i]);
      sq2_q[i] <= unsigned'(PROD_BITS'(d1_q[i] * d1_q[i]));
      dt2_q[i] <= d1_q[i] * ap1_q[i];
      d2_q[i]  <= d1_q[i];
      ap2_q[i] <= ap1_q[i];
      d3_q[i]  <= d2_q[i];
      ap3_q[i] <= ap2_q[i];
    end
    ab3_q  <= ACC_BITS'(sq2_q[0]) + ACC_BITS'(sq2_q[1]) + ACC_BITS'(sq2_q[2]);
    dot3_q <= ACC_BITS'(dt2_q[0]) + ACC_BITS'(dt2_q[1]) + ACC_BITS'(dt2_q[2]);
  end

  // Stage 4: classify the projection and take the integer quotient bit
  logic [ACC_BITS-1:0] dot_u;
  logic                dot_neg;
  logic                seg_zero;
  tag_t                tag4;
  logic [REM_BITS-1:0] rem4;

  assign dot_u    = unsigned'(dot3_q);
  assign dot_neg  = dot3_q[ACC_BITS-1];
  assign seg_zero = (ab3_q == '0);

  always_comb begin
    tag4.param = '0;
    tag4.degen = seg_zero;
    rem4       = '0;
    if (seg_zero || dot_neg) begin
      tag4.kind = KIND_START;
    end else if (dot_u > ab3_q) begin
      tag4.kind = KIND_END;
    end else begin
      tag4.kind = KIND_INTERIOR;
      if (dot_u == ab3_q) begin
        tag4.param = PARAM_ONE;
      end else begin
        rem4 = REM_BITS'(dot_u);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q[0]   <= rem4;
    dab_q[0]  <= ab3_q;
    dtag_q[0] <= tag4;
    for (int i = 0; i < AXES; i++) begin
      dd_q[0][i]  <= d3_q[i];
      dap_q[0][i] <= ap3_q[i];
    end
  end

  for (genvar k = 1; k <= T_BITS; k++) begin : g_div
    logic [REM_BITS-1:0] r_sh;
    logic                ge;
    tag_t                tag_d;

    assign r_sh = {dr_q[k-1][REM_BITS-2:0], 1'b0};
    assign ge   = (r_sh >= REM_BITS'(dab_q[k-1]));

    always_comb begin
      tag_d = dtag_q[k-1];
      tag_d.param[T_BITS-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dr_q[k]   <= ge ? r_sh - REM_BITS'(dab_q[k-1]) : r_sh;
      dab_q[k]  <= dab_q[k-1];
      dtag_q[k] <= tag_d;
      for (int i = 0; i < AXES; i++) begin
        dd_q[k][i]  <= dd_q[k-1][i];
        dap_q[k][i] <= dap_q[k-1][i];
      end
    end
  end

  // Offset stage: clamp t and scale each axis of the segment
  tag_t                  tag_m;
  logic [DIFF_BITS-1:0]  mag_d  [AXES];
  logic [SCALE_BITS-1:0] scaled [AXES];

  always_comb begin
    tag_m = dtag_q[T_BITS];
    case (tag_m.kind)
      KIND_INTERIOR: tag_m.param = dtag_q[T_BITS].param;
      KIND_END:      tag_m.param = PARAM_ONE;
      default:       tag_m.param = '0;
    endcase
    for (int i = 0; i < AXES; i++) begin
      mag_d[i]  = dd_q[T_BITS][i][DIFF_BITS-1] ? unsigned'(-dd_q[T_BITS][i])
                                                : unsigned'(dd_q[T_BITS][i]);
      scaled[i] = SCALE_BITS'(mag_d[i]) * SCALE_BITS'(tag_m.param)
                + (SCALE_BITS'(1) << (T_BITS - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    mtag_q <= tag_m;
    for (int i = 0; i < AXES; i++) begin
      off_q[i] <= scaled[i][T_BITS +: DIFF_BITS];
      neg_q[i] <= dd_q[T_BITS][i][DIFF_BITS-1];
      apm_q[i] <= dap_q[T_BITS][i];
    end
  end

  always_ff @(posedge clk_i) begin
    etag_q <= mtag_q;
    stag_q <= etag_q;
    ntag_q <= stag_q;
    for (int i = 0; i < AXES; i++) begin
      e_q[i] <= neg_q[i] ? ERR_BITS'(apm_q[i]) + signed'(ERR_BITS'(off_q[i]))
                         : ERR_BITS'(apm_q[i]) - signed'(ERR_BITS'(off_q[i]));
      esq_q[i] <= unsigned'(SQ_BITS'(e_q[i] * e_q[i]));
    end
    n_q <= SUM_BITS'(esq_q[0]) + SUM_BITS'(esq_q[1]) + SUM_BITS'(esq_q[2]);
  end

  // Square root, two radicand bits per stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q[0] <= 1'b0;
    end else begin
      rv_q[0] <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rn_q[0]    <= n_q;
    rrem_q[0]  <= '0;
    rroot_q[0] <= '0;
    rtag_q[0]  <= ntag_q;
  end

  for (genvar j = 1; j <= ROOT_BITS; j++) begin : g_sqrt
    logic [SREM_BITS-1:0] rem_t;
    logic [SREM_BITS-1:0] trial;
    logic                 ge;

    assign rem_t = {rrem_q[j-1][SREM_BITS-3:0], rn_q[j-1][SUM_BITS-1 -: 2]};
    assign trial = SREM_BITS'({rroot_q[j-1], 2'b01});
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[j] <= 1'b0;
      end else begin
        rv_q[j] <= rv_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rn_q[j]    <= {rn_q[j-1][SUM_BITS-3:0], 2'b00};
      rrem_q[j]  <= ge ? rem_t - trial : rem_t;
      rroot_q[j] <= {rroot_q[j-1][ROOT_BITS-2:0], ge};
      rtag_q[j]  <= rtag_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    distance_o   <= (|rroot_q[ROOT_BITS][ROOT_BITS-1:DIST_BITS]) ? '1
                  : rroot_q[ROOT_BITS][DIST_BITS-1:0];
    seg_param_o  <= rtag_q[ROOT_BITS].param;
    clamp_kind_o <= rtag_q[ROOT_BITS].kind;
    degenerate_o <= rtag_q[ROOT_BITS].degen;
  end

endmodule

// ----- rtl/psd_checker.sv -----
// Port-level assertions for the point-to-segment distance pipeline.
module psd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           busy,
  input logic                           done_o,
  input logic [psd_pkg::PARAM_BITS-1:0] seg_param_o,
  input psd_pkg::clamp_kind_e           clamp_kind_o,
  input logic                           degenerate_o
);
  import psd_pkg::*;

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_degen_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (clamp_kind_o == KIND_START && seg_param_o == '0))
    else $error("zero-length segment not reported at start");

  a_start_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clamp_kind_o == KIND_START) |-> (seg_param_o == '0))
    else $error("start clamp with nonzero parameter");

  a_end_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clamp_kind_o == KIND_END) |-> (seg_param_o == PARAM_ONE && !degenerate_o))
    else $error("end clamp with wrong parameter");

  a_param_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (seg_param_o <= PARAM_ONE))
    else $error("parameter above one");

endmodule

bind point_segment_distance psd_checker u_psd_checker (.*);
